// ----- rtl/core/ufhb_pkg.sv -----
// Shared types, constants and checksum helpers for the UDP frame header builder.
// No dependencies; imported by every module under rtl/core.
package ufhb_pkg;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_SOURCE_MAC = 2'd0;
	localparam logic [1:0] REG_DEST_MAC   = 2'd1;

	localparam logic [16:0] MAX_PAYLOAD = 17'd65507;

	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] IPV4_VER_IHL  = 16'h4500;
	localparam logic [15:0] IPV4_FLAG_DF  = 16'h4000;
	localparam logic [7:0]  IP_TTL        = 8'd64;
	localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
	// Top half of the IPv6 first word: version 6, class 0, flow label bits 19:16 = 3
	localparam logic [15:0] IPV6_FIRST_HI = 16'h6003;
	// Constant words of the IPv4 header checksum: ver/ihl + DF + TTL/proto
	localparam logic [15:0] IPV4_CSUM_FIX = 16'hC511;
	localparam logic [16:0] UDP_HDR_LEN   = 17'd8;
	localparam logic [16:0] IPV4_UDP_LEN  = 17'd28;
	localparam logic [16:0] FRAME_OVH_V4  = 17'd42;
	localparam logic [16:0] FRAME_OVH_V6  = 17'd62;

	localparam logic [2:0] LAST_WORD_V4  = 3'd5;
	localparam logic [2:0] LAST_WORD_V6  = 3'd7;
	localparam logic [3:0] TAIL_BYTES_V4 = 4'd2;
	localparam logic [3:0] TAIL_BYTES_V6 = 4'd6;
	localparam logic [3:0] FULL_BYTES    = 4'd8;

	// Header request handed from the accumulator to the header builder
	typedef struct packed {
		logic        is_ipv6;
		logic [63:0] src_addr_high;
		logic [63:0] src_addr_low;
		logic [63:0] dst_addr_high;
		logic [63:0] dst_addr_low;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] csum;      // folded payload sum
		logic [16:0] count;     // payload bytes, saturated
		logic        over;
		logic [20:0] addr_sum;  // IPv6 pseudo-header lanes, ports and protocol
	} hdr_req_t;

	// Sum of the four 16-bit lanes of a word
	function automatic logic [17:0] lanes(input logic [63:0] w);
		lanes = {2'b00, w[63:48]} + {2'b00, w[47:32]} + {2'b00, w[31:16]}
			+ {2'b00, w[15:0]};
	endfunction

	// End-around carry fold; two passes suffice for sums below 2**24
	function automatic logic [15:0] fold16(input logic [23:0] s);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, s[15:0]} + {9'b0, s[23:16]};
		f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
		fold16 = f2[15:0];
	endfunction

endpackage

// ----- rtl/core/ufhb_accum.sv -----
// Input register, payload checksum and byte count accumulator.
// Hands one header request per packet to ufhb_hdr; depends on ufhb_pkg.
module ufhb_accum import ufhb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_ipv6,
	input  logic [63:0] in_src_hi,
	input  logic [63:0] in_src_lo,
	input  logic [63:0] in_dst_hi,
	input  logic [63:0] in_dst_lo,
	input  logic [15:0] in_src_port,
	input  logic [15:0] in_dst_port,
	input  logic [63:0] in_word,
	input  logic [3:0]  in_bytes,
	input  logic        in_last,
	output logic        req_valid,
	input  logic        req_ready,
	output hdr_req_t    req
);

	logic        vld_s1;
	logic        ipv6_s1;
	logic [63:0] src_hi_s1, src_lo_s1, dst_hi_s1, dst_lo_s1;
	logic [15:0] src_port_s1, dst_port_s1;
	logic [63:0] word_s1;
	logic [3:0]  bytes_s1;
	logic        last_s1;

	logic [15:0] csum_q;
	logic [16:0] count_q;
	logic        over_q;

	logic        req_vld_s2;
	hdr_req_t    req_s2;

	logic        adv_s1;
	logic [3:0]  nbytes;
	logic [63:0] word_m;
	logic [18:0] csum_sum;
	logic [15:0] csum_nxt;
	logic [16:0] total;
	logic [16:0] count_nxt;
	logic        over_nxt;
	logic [20:0] addr_sum;

	// A last item waits only while the request register is full
	assign adv_s1   = vld_s1 && (!last_s1 || !req_vld_s2 || req_ready);
	assign in_ready = !vld_s1 || adv_s1;

	always_comb begin
		nbytes = (bytes_s1 > FULL_BYTES) ? FULL_BYTES : bytes_s1;
		for (int i = 0; i < 8; i++) begin
			word_m[63 - 8*i -: 8] = (4'(i) < nbytes) ? word_s1[63 - 8*i -: 8] : 8'h00;
		end
		csum_sum  = {3'b000, csum_q} + {1'b0, lanes(word_m)};
		csum_nxt  = fold16({5'b00000, csum_sum});
		total     = count_q + {13'b0, nbytes};
		over_nxt  = over_q || (total > MAX_PAYLOAD);
		count_nxt = (total > MAX_PAYLOAD) ? MAX_PAYLOAD : total;
		addr_sum  = {3'b000, lanes(src_hi_s1)} + {3'b000, lanes(src_lo_s1)}
			+ {3'b000, lanes(dst_hi_s1)} + {3'b000, lanes(dst_lo_s1)}
			+ {5'b0, src_port_s1} + {5'b0, dst_port_s1} + {13'b0, IP_PROTO_UDP};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ipv6_s1     <= in_ipv6;
			src_hi_s1   <= in_src_hi;
			src_lo_s1   <= in_src_lo;
			dst_hi_s1   <= in_dst_hi;
			dst_lo_s1   <= in_dst_lo;
			src_port_s1 <= in_src_port;
			dst_port_s1 <= in_dst_port;
			word_s1     <= in_word;
			bytes_s1    <= in_bytes;
			last_s1     <= in_last;
		end
	end

	// Running sums; clear once the last item has been folded in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q  <= '0;
			count_q <= '0;
			over_q  <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				csum_q  <= '0;
				count_q <= '0;
				over_q  <= 1'b0;
			end else begin
				csum_q  <= csum_nxt;
				count_q <= count_nxt;
				over_q  <= over_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			req_vld_s2 <= 1'b1;
		end else if (req_ready) begin
			req_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			req_s2.is_ipv6       <= ipv6_s1;
			req_s2.src_addr_high <= src_hi_s1;
			req_s2.src_addr_low  <= src_lo_s1;
			req_s2.dst_addr_high <= dst_hi_s1;
			req_s2.dst_addr_low  <= dst_lo_s1;
			req_s2.src_port      <= src_port_s1;
			req_s2.dst_port      <= dst_port_s1;
			req_s2.csum          <= csum_nxt;
			req_s2.count         <= count_nxt;
			req_s2.over          <= over_nxt;
			req_s2.addr_sum      <= addr_sum;
		end
	end

	assign req_valid = req_vld_s2;
	assign req       = req_s2;

endmodule

// ----- rtl/core/ufhb_hdr.sv -----
// Header checksum, header word assembly into the frame register, and word output.
// Takes one request from ufhb_accum per packet; depends on ufhb_pkg.
module ufhb_hdr import ufhb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [47:0] source_mac,
	input  logic [47:0] dest_mac,
	input  logic        req_valid,
	output logic        req_ready,
	input  hdr_req_t    req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_word,
	output logic [3:0]  out_bytes,
	output logic        out_last,
	output logic [16:0] out_frame_len,
	output logic        out_over
);

	logic [63:0] frame_q [8];
	logic        busy_q;
	logic [2:0]  idx_q;
	logic        v6_q;
	logic [16:0] flen_q;
	logic        over_q;

	logic        take;
	logic        done;
	logic [15:0] udp_len;
	logic [15:0] tot_len;
	logic [31:0] s4, d4;
	logic [23:0] sum4, sum6;
	logic [15:0] check4, check6;
	logic [15:0] swp;
	logic [63:0] words [8];
	logic [2:0]  last_idx;

	assign last_idx  = v6_q ? LAST_WORD_V6 : LAST_WORD_V4;
	assign out_valid = busy_q;
	assign out_last  = (idx_q == last_idx);
	assign done      = busy_q && out_ready && out_last;
	assign req_ready = !busy_q || done;
	assign take      = req_valid && req_ready;

	always_comb begin
		udp_len = 16'(req.count + UDP_HDR_LEN);
		tot_len = 16'(req.count + IPV4_UDP_LEN);
		s4      = req.src_addr_low[31:0];
		d4      = req.dst_addr_low[31:0];
		swp     = {req.src_port[7:0], req.src_port[15:8]};

		sum4 = {8'b0, IPV4_CSUM_FIX} + {8'b0, tot_len} + {8'b0, s4[31:16]}
			+ {8'b0, s4[15:0]} + {8'b0, d4[31:16]} + {8'b0, d4[15:0]};
		check4 = ~fold16(sum4);

		sum6 = {8'b0, req.csum} + {3'b000, req.addr_sum} + {7'b0, udp_len, 1'b0};
		check6 = ~fold16(sum6);
		if (check6 == 16'h0000) begin
			check6 = 16'hFFFF;
		end

		words[0] = {dest_mac, source_mac[47:32]};
		if (req.is_ipv6) begin
			words[1] = {source_mac[31:0], ETH_TYPE_IPV6, IPV6_FIRST_HI};
			words[2] = {swp, udp_len, IP_PROTO_UDP, IP_TTL, req.src_addr_high[63:48]};
			words[3] = {req.src_addr_high[47:0], req.src_addr_low[63:48]};
			words[4] = {req.src_addr_low[47:0], req.dst_addr_high[63:48]};
			words[5] = {req.dst_addr_high[47:0], req.dst_addr_low[63:48]};
			words[6] = {req.dst_addr_low[47:0], req.src_port};
			words[7] = {req.dst_port, udp_len, check6, 16'h0000};
		end else begin
			words[1] = {source_mac[31:0], ETH_TYPE_IPV4, IPV4_VER_IHL};
			words[2] = {tot_len, 16'h0000, IPV4_FLAG_DF, IP_TTL, IP_PROTO_UDP};
			words[3] = {check4, s4, d4[31:16]};
			words[4] = {d4[15:0], req.src_port, req.dst_port, udp_len};
			// UDP checksum is not used over IPv4
			words[5] = 64'h0;
			words[6] = 64'h0;
			words[7] = 64'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < 8; k++) begin
				frame_q[k] <= words[k];
			end
			v6_q   <= req.is_ipv6;
			flen_q <= req.count + (req.is_ipv6 ? FRAME_OVH_V6 : FRAME_OVH_V4);
			over_q <= req.over;
		end
	end

	assign out_word      = frame_q[idx_q];
	assign out_bytes     = !out_last ? FULL_BYTES : (v6_q ? TAIL_BYTES_V6 : TAIL_BYTES_V4);
	assign out_frame_len = flen_q;
	assign out_over      = over_q;

endmodule

// ----- rtl/core/udp_frame_header_builder.sv -----
// Top level of the UDP frame header builder: MAC registers, accumulator, header stage.
// Depends on ufhb_pkg, ufhb_accum and ufhb_hdr.
//
//  channel | direction | tdata (low bit up)                                   | tuser    | tlast
//  s_*     | in        | src_addr_high, src_addr_low, dst_addr_high,          | is_ipv6  | last
//          |           | dst_addr_low, src_port, dst_port, data_word,          |          |
//          |           | data_bytes                                            |          |
//  m_*     | out       | header_word, word_bytes, frame_len                    | oversize | header_last
//  cfg_*   | in        | cfg_idx selects source_mac (0) or dest_mac (1)        | -        | -
//
// Payload items are taken one per cycle. After the transaction of its last item, a packet's
// header passes the input register and the request register into the frame register; the
// packet yields 6 (IPv4) or 8 (IPv6) output words, one per cycle while m_tready is high, and
// the single frame register sets that rate. A last item stalls only while the previous header
// is still being sent and the request register is full.
// Reset clears the running sums and the MAC registers; no clearing pass.
module udp_frame_header_builder import ufhb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [359:0] s_tdata,   // src_addr_high, src_addr_low, dst_addr_high,
	                                // dst_addr_low, src_port, dst_port, data_word,
	                                // data_bytes, zero pad
	input  logic         s_tuser,   // is_ipv6
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,   // header_word, word_bytes, frame_len, zero pad
	output logic         m_tuser,   // oversize
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [47:0]  cfg_wdata
);

	logic [47:0] source_mac_q;
	logic [47:0] dest_mac_q;
	logic        req_valid;
	logic        req_ready;
	hdr_req_t    req;
	logic [63:0] hdr_word;
	logic [3:0]  hdr_bytes;
	logic [16:0] hdr_flen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mac_q <= '0;
			dest_mac_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SOURCE_MAC: source_mac_q <= cfg_wdata;
				REG_DEST_MAC:   dest_mac_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ufhb_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_ipv6     (s_tuser),
		.in_src_hi   (s_tdata[63:0]),
		.in_src_lo   (s_tdata[127:64]),
		.in_dst_hi   (s_tdata[191:128]),
		.in_dst_lo   (s_tdata[255:192]),
		.in_src_port (s_tdata[271:256]),
		.in_dst_port (s_tdata[287:272]),
		.in_word     (s_tdata[351:288]),
		.in_bytes    (s_tdata[355:352]),
		.in_last     (s_tlast),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req)
	);

	ufhb_hdr u_hdr (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_mac    (source_mac_q),
		.dest_mac      (dest_mac_q),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_word      (hdr_word),
		.out_bytes     (hdr_bytes),
		.out_last      (m_tlast),
		.out_frame_len (hdr_flen),
		.out_over      (m_tuser)
	);

	assign m_tdata = {3'b000, hdr_flen, hdr_bytes, hdr_word};

`ifndef SYNTHESIS
	a_tail_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[67:64] == TAIL_BYTES_V4
			|| m_tdata[67:64] == TAIL_BYTES_V6)
		else $error("final header word has a bad byte count");

	a_full_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[67:64] == FULL_BYTES)
		else $error("inner header word is not full");

	a_len_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
			&& m_tdata[84:68] == $past(m_tdata[84:68]))
		else $error("frame length changed inside a header run");

	a_over_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[84:68] == MAX_PAYLOAD + FRAME_OVH_V4
			|| m_tdata[84:68] == MAX_PAYLOAD + FRAME_OVH_V6)
		else $error("oversize frame without a saturated length");
`endif

endmodule
